// ===== hw/rtl/rsa_pkg.sv =====
// Package for the running statistics accumulator.
// Holds operation codes and the fixed widths shared by the interfaces and modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rsa_pkg;

  // Operation codes carried in the func field
  localparam logic [1:0] FN_RECORD = 2'd0;
  localparam logic [1:0] FN_MERGE  = 2'd1;
  localparam logic [1:0] FN_CLEAR  = 2'd2;
  localparam logic [1:0] FN_QUERY  = 2'd3;

  // Sum of squares is always a 64-bit saturating quantity
  localparam int SQ_BITS = 64;
  // Working width of the variance numerator, quotient and root radicand
  localparam int NUM_W   = 128;

  // Status of the serial math engine
  typedef struct packed {
    logic busy;
    logic done;
  } eng_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rsa_req_if.sv =====
// Request channel of the running statistics accumulator.
// Depends on rsa_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface rsa_req_if import rsa_pkg::*; #(
  parameter int SAMPLE_BITS = 20,
  parameter int COUNT_BITS  = 24
);
  localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;

  logic                        valid;
  logic                        ready;
  logic [1:0]                  func;
  logic [SAMPLE_BITS-1:0]      sample;
  logic [COUNT_BITS-1:0]       other_count;
  logic [SUM_BITS-1:0]         other_sum;
  logic [SQ_BITS-1:0]          other_sqsum;
  logic signed [SAMPLE_BITS:0] other_min;
  logic signed [SAMPLE_BITS:0] other_max;

  modport source (output valid, func, sample, other_count, other_sum, other_sqsum,
                  other_min, other_max, input ready);
  modport sink (input valid, func, sample, other_count, other_sum, other_sqsum,
                other_min, other_max, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rsa_rsp_if.sv =====
// Result channel of the running statistics accumulator.
// Depends on rsa_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface rsa_rsp_if import rsa_pkg::*; #(
  parameter int SAMPLE_BITS = 20,
  parameter int COUNT_BITS  = 24,
  parameter int FRAC_BITS   = 8
);
  localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;

  logic                                  valid;
  logic                                  ready;
  logic [COUNT_BITS-1:0]                 total_count;
  logic [SUM_BITS-1:0]                   total_sum;
  logic [SQ_BITS-1:0]                    total_sqsum;
  logic signed [SAMPLE_BITS:0]           smallest;
  logic signed [SAMPLE_BITS:0]           largest;
  logic [SAMPLE_BITS-1:0]                average;
  logic signed [SAMPLE_BITS+FRAC_BITS:0] std_dev;
  logic                                  overflowed;

  modport source (output valid, total_count, total_sum, total_sqsum, smallest, largest,
                  average, std_dev, overflowed, input ready);
  modport sink (input valid, total_count, total_sum, total_sqsum, smallest, largest,
                average, std_dev, overflowed, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rsa_engine.sv =====
// Serial math engine: mean, variance numerator, division and square root.
// Shift-add multiplier, restoring dividers and digit-by-digit root. Depends on rsa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rsa_engine import rsa_pkg::*; #(
  parameter int SAMPLE_BITS = 20,
  parameter int COUNT_BITS  = 24,
  parameter int FRAC_BITS   = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [COUNT_BITS-1:0]                 count,
  input  logic [SAMPLE_BITS+COUNT_BITS-1:0]     sum,
  input  logic [SQ_BITS-1:0]                    sqsum,
  output eng_stat_t                             stat,
  output logic [SAMPLE_BITS-1:0]                average,
  output logic signed [SAMPLE_BITS+FRAC_BITS:0] std_dev
);
  localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
  localparam int DW       = 2 * COUNT_BITS;
  localparam int ROOT_W   = NUM_W / 2;
  localparam int SR_W     = ROOT_W + 3;
  localparam int STD_W    = SAMPLE_BITS + FRAC_BITS;
  localparam int STEP_W   = $clog2(NUM_W + 1);

  typedef enum logic [2:0] {
    E_IDLE, E_MULA, E_MULB, E_SUB, E_DIV, E_SQRT, E_DONE
  } phase_t;

  phase_t              phase;
  logic [STEP_W-1:0]   steps;
  logic [NUM_W-1:0]    acc;
  logic [NUM_W-1:0]    mcand;
  logic [SUM_BITS-1:0] mplier;
  logic [NUM_W-1:0]    num;
  logic [DW-1:0]       dvs;
  logic [DW-1:0]       rem;
  logic [SUM_BITS-1:0] aq;
  logic [COUNT_BITS-1:0] ar;
  logic [ROOT_W-1:0]   root;
  logic [SR_W-1:0]     srem;
  logic                neg;

  logic [NUM_W-1:0]      acc_add;
  logic [DW:0]           div_ext;
  logic                  div_ge;
  logic [DW:0]           div_dif;
  logic [COUNT_BITS:0]   avg_ext;
  logic                  avg_ge;
  logic [COUNT_BITS:0]   avg_dif;
  logic [SR_W-1:0]       sq_sh;
  logic [SR_W-1:0]       trial;
  logic                  sq_ge;
  logic [SR_W-1:0]       sq_dif;
  logic                  last;
  logic [COUNT_BITS-1:0] cnt_m1;

  // one step of each serial unit
  always_comb begin
    acc_add = mplier[0] ? acc + mcand : acc;
    div_ext = {rem, num[NUM_W-1]};
    div_ge  = div_ext >= {1'b0, dvs};
    div_dif = div_ext - {1'b0, dvs};
    avg_ext = {ar, aq[SUM_BITS-1]};
    avg_ge  = avg_ext >= {1'b0, count};
    avg_dif = avg_ext - {1'b0, count};
    sq_sh   = {srem[SR_W-3:0], num[NUM_W-1 -: 2]};
    trial   = {1'b0, root, 2'b01};
    sq_ge   = sq_sh >= trial;
    sq_dif  = sq_sh - trial;
    last    = steps == STEP_W'(1);
    cnt_m1  = count - COUNT_BITS'(1);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= E_IDLE;
      steps <= '0;
    end else begin
      case (phase)
        E_IDLE: begin
          if (start) begin
            acc    <= '0;
            mcand  <= NUM_W'(sqsum);
            mplier <= SUM_BITS'(count);
            dvs    <= DW'(count) * DW'(cnt_m1);
            aq     <= sum;
            ar     <= '0;
            neg    <= 1'b0;
            steps  <= STEP_W'(COUNT_BITS);
            phase  <= E_MULA;
          end
        end
        // sqsum * count
        E_MULA: begin
          if (last) begin
            num    <= acc_add;
            acc    <= '0;
            mcand  <= NUM_W'(sum);
            mplier <= sum;
            steps  <= STEP_W'(SUM_BITS);
            phase  <= E_MULB;
          end else begin
            mcand  <= mcand << 1;
            mplier <= mplier >> 1;
            steps  <= steps - STEP_W'(1);
            acc    <= acc_add;
          end
        end
        // sum * sum, with the mean division alongside
        E_MULB: begin
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          acc    <= acc_add;
          steps  <= steps - STEP_W'(1);
          ar     <= avg_ge ? avg_dif[COUNT_BITS-1:0] : avg_ext[COUNT_BITS-1:0];
          aq     <= {aq[SUM_BITS-2:0], avg_ge};
          if (last) phase <= E_SUB;
        end
        E_SUB: begin
          if (num < acc) neg <= 1'b1;
          num   <= (num - acc) << (2 * FRAC_BITS);
          rem   <= '0;
          steps <= STEP_W'(NUM_W);
          phase <= E_DIV;
        end
        // restoring division by count*(count-1)
        E_DIV: begin
          rem   <= div_ge ? div_dif[DW-1:0] : div_ext[DW-1:0];
          num   <= {num[NUM_W-2:0], div_ge};
          if (last) begin
            srem  <= '0;
            root  <= '0;
            steps <= STEP_W'(ROOT_W);
            phase <= E_SQRT;
          end else begin
            steps <= steps - STEP_W'(1);
          end
        end
        // two radicand bits per step
        E_SQRT: begin
          srem  <= sq_ge ? sq_dif : sq_sh;
          root  <= {root[ROOT_W-2:0], sq_ge};
          num   <= num << 2;
          steps <= steps - STEP_W'(1);
          if (last) phase <= E_DONE;
        end
        E_DONE:  phase <= E_IDLE;
        default: phase <= E_IDLE;
      endcase
    end
  end

  // final selection and saturation
  always_comb begin
    stat.busy = phase != E_IDLE;
    stat.done = phase == E_DONE;
    if (count == '0) average = '0;
    else if (|aq[SUM_BITS-1:SAMPLE_BITS]) average = '1;
    else average = aq[SAMPLE_BITS-1:0];
    if (count < COUNT_BITS'(2)) std_dev = '1;
    else if (neg) std_dev = '0;
    else if (|root[ROOT_W-1:STD_W]) std_dev = {1'b0, {STD_W{1'b1}}};
    else std_dev = {1'b0, root[STD_W-1:0]};
  end

endmodule
`default_nettype wire

// ===== hw/rtl/running_statistics_accumulator.sv =====
// Top level of the running statistics accumulator: state registers, handshakes,
// result register. Depends on rsa_pkg, rsa_req_if, rsa_rsp_if and rsa_engine.
//
//   channel | dir | payload
//   req     | in  | func, sample, other_count/sum/sqsum/min/max
//   rsp     | out | totals, smallest, largest, average, std_dev, overflowed
//
// After a word is taken, its result is computed by the serial multiplier, the divider and
// the root in turn; no new word is taken until that result reaches the result register.
// Reset is synchronous, active high; it empties the aggregate and the result register.
// A new word is taken once the previous result sits in the result register, even if
// rsp is stalled; a stalled rsp holds back only the following result.
`timescale 1ns / 1ps
`default_nettype none
module running_statistics_accumulator import rsa_pkg::*; #(
  parameter int SAMPLE_BITS = 20,
  parameter int COUNT_BITS  = 24,
  parameter int FRAC_BITS   = 8
) (
  input logic clk,
  input logic rst,
  rsa_req_if.sink   req,
  rsa_rsp_if.source rsp
);
  localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
  localparam int EXT_BITS = SAMPLE_BITS + 1;

  typedef enum logic [1:0] {ST_IDLE, ST_BUSY, ST_PEND} state_t;

  state_t                       state;
  logic                         start;
  logic [COUNT_BITS-1:0]        count_reg, count_next;
  logic [SUM_BITS-1:0]          sum_reg, sum_next;
  logic [SQ_BITS-1:0]           sqsum_reg, sqsum_next;
  logic signed [EXT_BITS-1:0]   min_reg, min_next;
  logic signed [EXT_BITS-1:0]   max_reg, max_next;
  logic                         overflow_flag, overflow_next;

  logic                         out_valid;
  logic [COUNT_BITS-1:0]        out_count;
  logic [SUM_BITS-1:0]          out_sum;
  logic [SQ_BITS-1:0]           out_sqsum;
  logic signed [EXT_BITS-1:0]   out_min, out_max;
  logic [SAMPLE_BITS-1:0]       out_avg;
  logic signed [SAMPLE_BITS+FRAC_BITS:0] out_std;
  logic                         out_ovf;

  eng_stat_t                    stat;
  logic [SAMPLE_BITS-1:0]       eng_avg;
  logic signed [SAMPLE_BITS+FRAC_BITS:0] eng_std;

  logic                         accept;
  logic                         load;
  logic                         is_rec;
  logic [2*SAMPLE_BITS-1:0]     samp_sq;
  logic [COUNT_BITS-1:0]        add_c;
  logic [SUM_BITS-1:0]          add_s;
  logic [SQ_BITS-1:0]           add_q;
  logic signed [EXT_BITS-1:0]   cand_min, cand_max;
  logic [COUNT_BITS:0]          c_sum;
  logic [SUM_BITS:0]            s_sum;
  logic [SQ_BITS:0]             q_sum;

  assign accept    = req.valid && req.ready;
  assign req.ready = state == ST_IDLE;
  // result register takes the finished word
  assign load      = state == ST_PEND && (!out_valid || rsp.ready);

  // aggregate update for the accepted word
  always_comb begin
    is_rec   = req.func == FN_RECORD;
    samp_sq  = (2*SAMPLE_BITS)'(req.sample) * (2*SAMPLE_BITS)'(req.sample);
    add_c    = is_rec ? COUNT_BITS'(1) : req.other_count;
    add_s    = is_rec ? SUM_BITS'(req.sample) : req.other_sum;
    add_q    = is_rec ? SQ_BITS'(samp_sq) : req.other_sqsum;
    cand_min = is_rec ? $signed({1'b0, req.sample}) : req.other_min;
    cand_max = is_rec ? $signed({1'b0, req.sample}) : req.other_max;
    c_sum    = {1'b0, count_reg} + {1'b0, add_c};
    s_sum    = {1'b0, sum_reg} + {1'b0, add_s};
    q_sum    = {1'b0, sqsum_reg} + {1'b0, add_q};

    count_next    = count_reg;
    sum_next      = sum_reg;
    sqsum_next    = sqsum_reg;
    min_next      = min_reg;
    max_next      = max_reg;
    overflow_next = overflow_flag;
    case (req.func)
      FN_RECORD, FN_MERGE: begin
        if (add_c != '0) begin
          if (count_reg == '0) begin
            count_next = add_c;
            sum_next   = add_s;
            sqsum_next = add_q;
            min_next   = cand_min;
            max_next   = cand_max;
          end else begin
            count_next = c_sum[COUNT_BITS] ? '1 : c_sum[COUNT_BITS-1:0];
            sum_next   = s_sum[SUM_BITS] ? '1 : s_sum[SUM_BITS-1:0];
            sqsum_next = q_sum[SQ_BITS] ? '1 : q_sum[SQ_BITS-1:0];
            if (c_sum[COUNT_BITS] || s_sum[SUM_BITS] || q_sum[SQ_BITS]) overflow_next = 1'b1;
            if (cand_min < min_reg) min_next = cand_min;
            if (cand_max > max_reg) max_next = cand_max;
          end
        end
      end
      FN_CLEAR: begin
        count_next    = '0;
        sum_next      = '0;
        sqsum_next    = '0;
        min_next      = '1;
        max_next      = '1;
        overflow_next = 1'b0;
      end
      FN_QUERY: ;
      default: ;
    endcase
  end

  // state, control and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      start         <= 1'b0;
      out_valid     <= 1'b0;
      count_reg     <= '0;
      sum_reg       <= '0;
      sqsum_reg     <= '0;
      min_reg       <= '1;
      max_reg       <= '1;
      overflow_flag <= 1'b0;
    end else begin
      start <= 1'b0;
      if (load) out_valid <= 1'b1;
      else if (out_valid && rsp.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            sqsum_reg     <= sqsum_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            overflow_flag <= overflow_next;
            start         <= 1'b1;
            state         <= ST_BUSY;
          end
        end
        ST_BUSY: if (stat.done) state <= ST_PEND;
        ST_PEND: begin
          if (load) begin
            out_count <= count_reg;
            out_sum   <= sum_reg;
            out_sqsum <= sqsum_reg;
            out_min   <= min_reg;
            out_max   <= max_reg;
            out_avg   <= eng_avg;
            out_std   <= eng_std;
            out_ovf   <= overflow_flag;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  rsa_engine #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .count  (count_reg),
    .sum    (sum_reg),
    .sqsum  (sqsum_reg),
    .stat   (stat),
    .average(eng_avg),
    .std_dev(eng_std)
  );

  assign rsp.valid       = out_valid;
  assign rsp.total_count = out_count;
  assign rsp.total_sum   = out_sum;
  assign rsp.total_sqsum = out_sqsum;
  assign rsp.smallest    = out_min;
  assign rsp.largest     = out_max;
  assign rsp.average     = out_avg;
  assign rsp.std_dev     = out_std;
  assign rsp.overflowed  = out_ovf;

`ifndef SYNTHESIS
  // an empty aggregate carries no sums
  a_empty_sums: assert property (@(posedge clk) disable iff (rst)
    count_reg == '0 |-> sum_reg == '0 && sqsum_reg == '0)
    else $error("empty aggregate with nonzero sums");
  // an accepted word always starts the engine
  a_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> start && !stat.busy)
    else $error("accepted word did not start engine");
  // the engine finishes only for a word in flight
  a_done: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> state == ST_BUSY)
    else $error("engine done outside busy state");
`endif

endmodule
`default_nettype wire
